// ===== rtl/core/resident_id_number_validator_macros.svh =====
// ----------------------------------------------------------------------------
// Resident ID number validator assertion macros
// Concurrent assertion wrappers that vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef RESIDENT_ID_NUMBER_VALIDATOR_MACROS_SVH
`define RESIDENT_ID_NUMBER_VALIDATOR_MACROS_SVH

`ifndef SYNTHESIS

`define RIDV_ASSERT_IMPLY(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

`define RIDV_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`else

`define RIDV_ASSERT_IMPLY(name, clk, rst, ante, cons)

`define RIDV_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/core/ridv_pkg.sv =====
// ----------------------------------------------------------------------------
// Resident ID number validator package
// Payload types, status codes, register indexes and constant tables.
// ----------------------------------------------------------------------------
package ridv_pkg;

  localparam int NUM_DIGITS = 17;

  localparam logic [4:0] COUNT_MAX  = 5'd31;
  localparam logic [4:0] LEN_SHORT  = 5'd15;
  localparam logic [4:0] LEN_LONG   = 5'd18;
  localparam logic [4:0] POS_CHECK  = 5'd17;
  localparam logic [4:0] POS_SPLIT  = 5'd15;

  localparam logic [6:0]  PROV_LOW  = 7'd11;
  localparam logic [6:0]  PROV_HIGH = 7'd65;
  localparam logic [13:0] YEAR_LOW  = 14'd1900;

  localparam logic [3:0] CENTURY_HI = 4'd1;
  localparam logic [3:0] CENTURY_LO = 4'd9;

  localparam logic [2:0] ST_VALID    = 3'd0;
  localparam logic [2:0] ST_LENGTH   = 3'd1;
  localparam logic [2:0] ST_DIGIT    = 3'd2;
  localparam logic [2:0] ST_CHECK    = 3'd3;
  localparam logic [2:0] ST_PROVINCE = 3'd4;
  localparam logic [2:0] ST_DATE     = 3'd5;

  localparam logic [1:0] CFG_TODAY_YEAR  = 2'd0;
  localparam logic [1:0] CFG_TODAY_MONTH = 2'd1;
  localparam logic [1:0] CFG_TODAY_DAY   = 2'd2;

  localparam logic [13:0] RESET_YEAR  = 14'd2024;
  localparam logic [3:0]  RESET_MONTH = 4'd1;
  localparam logic [4:0]  RESET_DAY   = 5'd1;

  typedef logic [3:0] digit_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } char_t;

  typedef struct packed {
    logic [2:0] status;
    logic       gender;
  } result_t;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } today_t;

  typedef struct packed {
    logic [4:0]                  count;
    logic [3:0]                  sum;
    logic                        nd_first15;
    logic                        nd_16_17;
    logic [7:0]                  check_char;
    digit_t [NUM_DIGITS-1:0]     digits;
  } number_t;

  function automatic logic [3:0] weight(input logic [4:0] pos);
    logic [3:0] w;
    case (pos)
      5'd0:    w = 4'd7;
      5'd1:    w = 4'd9;
      5'd2:    w = 4'd10;
      5'd3:    w = 4'd5;
      5'd4:    w = 4'd8;
      5'd5:    w = 4'd4;
      5'd6:    w = 4'd2;
      5'd7:    w = 4'd1;
      5'd8:    w = 4'd6;
      5'd9:    w = 4'd3;
      5'd10:   w = 4'd7;
      5'd11:   w = 4'd9;
      5'd12:   w = 4'd10;
      5'd13:   w = 4'd5;
      5'd14:   w = 4'd8;
      5'd15:   w = 4'd4;
      5'd16:   w = 4'd2;
      default: w = 4'd0;
    endcase
    return w;
  endfunction

  function automatic logic [7:0] check_symbol(input logic [3:0] sum);
    logic [7:0] c;
    case (sum)
      4'd0:    c = "1";
      4'd1:    c = "0";
      4'd2:    c = "X";
      4'd3:    c = "9";
      4'd4:    c = "8";
      4'd5:    c = "7";
      4'd6:    c = "6";
      4'd7:    c = "5";
      4'd8:    c = "4";
      4'd9:    c = "3";
      4'd10:   c = "2";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [4:0] month_length(input logic [3:0] month);
    logic [4:0] n;
    case (month)
      4'd2:    n = 5'd28;
      4'd4:    n = 5'd30;
      4'd6:    n = 5'd30;
      4'd9:    n = 5'd30;
      4'd11:   n = 5'd30;
      default: n = 5'd31;
    endcase
    return n;
  endfunction

  // Remainder by eleven for values below 110: the quotient is the number
  // of multiples of eleven that do not exceed the value.
  function automatic logic [3:0] mod11(input logic [6:0] v);
    logic [3:0] q;
    logic [6:0] r;
    q = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if (v >= 7'(11 * k)) begin
        q = q + 4'd1;
      end
    end
    r = v - 7'(11 * int'(q));
    return r[3:0];
  endfunction

endpackage

// ===== rtl/core/ridv_final_check.sv =====
// ----------------------------------------------------------------------------
// Resident ID number final check
// Evaluates a complete number: length, digits, check character, province and
// birth date, and derives the gender bit from the sequence number.
// ----------------------------------------------------------------------------
module ridv_final_check (
  input  ridv_pkg::number_t number,
  input  ridv_pkg::today_t  today,
  output ridv_pkg::result_t result
);

  ridv_pkg::digit_t [ridv_pkg::NUM_DIGITS-1:0] a;
  logic        is_short;
  logic [7:0]  check_up;
  logic [6:0]  prov;
  logic [6:0]  cent_hi;
  logic [6:0]  cent_lo;
  logic [13:0] year;
  logic [6:0]  month;
  logic [6:0]  day;
  logic [6:0]  today_month;
  logic [6:0]  today_day;
  logic        year_ok;
  logic        bound_ok;
  logic        month_ok;
  logic        leap;
  logic [4:0]  day_limit;
  logic        day_ok;
  logic        date_ok;
  logic [2:0]  status;

  assign is_short = (number.count == ridv_pkg::LEN_SHORT);

  // The short form gets the century digits inserted after the sixth digit.
  always_comb begin
    for (int i = 0; i < ridv_pkg::NUM_DIGITS; i++) begin
      if (i < 6) begin
        a[i] = number.digits[i];
      end else if (i == 6) begin
        a[i] = is_short ? ridv_pkg::CENTURY_HI : number.digits[i];
      end else if (i == 7) begin
        a[i] = is_short ? ridv_pkg::CENTURY_LO : number.digits[i];
      end else begin
        a[i] = is_short ? number.digits[i-2] : number.digits[i];
      end
    end
  end

  always_comb begin
    if (number.check_char inside {["a":"z"]}) begin
      check_up = number.check_char - 8'h20;
    end else begin
      check_up = number.check_char;
    end
  end

  assign prov    = 7'(a[0]) * 7'd10 + 7'(a[1]);
  assign cent_hi = 7'(a[6]) * 7'd10 + 7'(a[7]);
  assign cent_lo = 7'(a[8]) * 7'd10 + 7'(a[9]);
  assign year    = 14'(cent_hi) * 14'd100 + 14'(cent_lo);
  assign month   = 7'(a[10]) * 7'd10 + 7'(a[11]);
  assign day     = 7'(a[12]) * 7'd10 + 7'(a[13]);

  assign today_month = 7'(today.month);
  assign today_day   = 7'(today.day);

  assign year_ok  = (year >= ridv_pkg::YEAR_LOW) && (year <= today.year);
  assign bound_ok = (year < today.year) ||
                    ((year == today.year) &&
                     ((month < today_month) ||
                      ((month == today_month) && (day <= today_day))));
  assign month_ok = (month >= 7'd1) && (month <= 7'd12);

  assign leap = ((year[1:0] == 2'd0) && (cent_lo != 7'd0)) ||
                ((cent_lo == 7'd0) && (cent_hi[1:0] == 2'd0));

  always_comb begin
    if ((month == 7'd2) && leap) begin
      day_limit = 5'd29;
    end else begin
      day_limit = ridv_pkg::month_length(month[3:0]);
    end
  end

  assign day_ok  = (day >= 7'd1) && (day <= 7'(day_limit));
  assign date_ok = year_ok && bound_ok && month_ok && day_ok;

  always_comb begin
    status = ridv_pkg::ST_VALID;
    if (is_short) begin
      if (number.nd_first15) begin
        status = ridv_pkg::ST_DIGIT;
      end
    end else if (number.count == ridv_pkg::LEN_LONG) begin
      if (number.nd_first15 || number.nd_16_17) begin
        status = ridv_pkg::ST_DIGIT;
      end else if (check_up != ridv_pkg::check_symbol(number.sum)) begin
        status = ridv_pkg::ST_CHECK;
      end
    end else begin
      status = ridv_pkg::ST_LENGTH;
    end
    if (status == ridv_pkg::ST_VALID) begin
      if ((prov < ridv_pkg::PROV_LOW) || (prov > ridv_pkg::PROV_HIGH)) begin
        status = ridv_pkg::ST_PROVINCE;
      end else if (!date_ok) begin
        status = ridv_pkg::ST_DATE;
      end
    end
  end

  assign result.status = status;
  assign result.gender = (status == ridv_pkg::ST_VALID) ? a[16][0] : 1'b0;

endmodule

// ===== rtl/core/resident_id_number_validator.sv =====
// ----------------------------------------------------------------------------
// Resident ID number validator
// Checks an ID number given one ASCII character per transaction and returns
// one status and gender transaction after the last character.
//
//   Channel  Handshake             Payload
//   char     char_valid/stall      char_data (char_code, last_char)
//   result   result_valid/stall    result_data (status, gender)
//   cfg      cfg_valid/ready       cfg_index, cfg_data
//
// One character is taken every cycle unless the input stalls. A character is
// held in the input register, and a last character loads the result register
// as it leaves the input register.
// The only stall comes from a last character meeting a full, stalled result
// register. Reset is synchronous, clears the running number state and loads
// the reset value of today's date. The configuration port is always ready.
// ----------------------------------------------------------------------------
`include "resident_id_number_validator_macros.svh"

module resident_id_number_validator (
  input  logic               clk,
  input  logic               rst,
  input  logic               char_valid,
  output logic               char_stall,
  input  ridv_pkg::char_t    char_data,
  output logic               result_valid,
  input  logic               result_stall,
  output ridv_pkg::result_t  result_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [13:0]        cfg_data
);

  ridv_pkg::char_t   char_q;
  logic              char_q_valid;
  logic              advance;

  logic [4:0]        char_count;
  logic [3:0]        sum;
  logic              nd_first15;
  logic              nd_16_17;
  logic [7:0]        check_char;
  ridv_pkg::digit_t  digit_store [ridv_pkg::NUM_DIGITS];

  logic              is_digit;
  ridv_pkg::digit_t  digit_value;
  logic              in_store;
  logic [4:0]        char_count_next;
  logic [3:0]        sum_next;
  logic              nd_first15_next;
  logic              nd_16_17_next;
  logic [7:0]        check_char_next;

  ridv_pkg::today_t  today;
  ridv_pkg::number_t number;
  ridv_pkg::result_t final_result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      today.year  <= ridv_pkg::RESET_YEAR;
      today.month <= ridv_pkg::RESET_MONTH;
      today.day   <= ridv_pkg::RESET_DAY;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ridv_pkg::CFG_TODAY_YEAR:  today.year  <= cfg_data;
        ridv_pkg::CFG_TODAY_MONTH: today.month <= cfg_data[3:0];
        ridv_pkg::CFG_TODAY_DAY:   today.day   <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  assign advance    = char_q_valid &&
                      (!char_q.last_char || !result_valid || !result_stall);
  assign char_stall = char_q_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      char_q_valid <= 1'b0;
    end else if (!char_stall) begin
      char_q_valid <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!char_stall) begin
      char_q <= char_data;
    end
  end

  assign is_digit    = char_q.char_code inside {["0":"9"]};
  assign digit_value = is_digit ? char_q.char_code[3:0] : 4'd0;
  assign in_store    = (char_count < 5'(ridv_pkg::NUM_DIGITS));

  always_comb begin
    if (in_store) begin
      sum_next = ridv_pkg::mod11(7'(sum) +
                                 7'(ridv_pkg::weight(char_count)) * 7'(digit_value));
    end else begin
      sum_next = sum;
    end
  end

  assign nd_first15_next = nd_first15 ||
                           ((char_count < ridv_pkg::POS_SPLIT) && !is_digit);
  assign nd_16_17_next   = nd_16_17 ||
                           (in_store && (char_count >= ridv_pkg::POS_SPLIT) && !is_digit);
  assign check_char_next = (char_count == ridv_pkg::POS_CHECK) ? char_q.char_code
                                                                : check_char;
  assign char_count_next = (char_count == ridv_pkg::COUNT_MAX) ? ridv_pkg::COUNT_MAX
                                                                : char_count + 5'd1;

  always_comb begin
    number.count      = char_count_next;
    number.sum        = sum_next;
    number.nd_first15 = nd_first15_next;
    number.nd_16_17   = nd_16_17_next;
    number.check_char = check_char_next;
    for (int i = 0; i < ridv_pkg::NUM_DIGITS; i++) begin
      number.digits[i] = (char_count == 5'(i)) ? digit_value : digit_store[i];
    end
  end

  ridv_final_check u_final_check (
    .number (number),
    .today  (today),
    .result (final_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      char_count <= '0;
      sum        <= '0;
      nd_first15 <= 1'b0;
      nd_16_17   <= 1'b0;
      check_char <= '0;
    end else if (advance) begin
      if (char_q.last_char) begin
        char_count <= '0;
        sum        <= '0;
        nd_first15 <= 1'b0;
        nd_16_17   <= 1'b0;
        check_char <= '0;
      end else begin
        char_count <= char_count_next;
        sum        <= sum_next;
        nd_first15 <= nd_first15_next;
        nd_16_17   <= nd_16_17_next;
        check_char <= check_char_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_store) begin
      digit_store[char_count] <= digit_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && char_q.last_char) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && char_q.last_char) begin
      result_data <= final_result;
    end
  end

  `RIDV_ASSERT_IMPLY(a_gender_only_valid, clk, rst, result_valid && result_data.gender, result_data.status == ridv_pkg::ST_VALID)
  `RIDV_ASSERT_NEXT(a_clear_after_last, clk, rst, advance && char_q.last_char, char_count == 5'd0)
  `RIDV_ASSERT_IMPLY(a_stall_cause, clk, rst, char_stall, char_q_valid && char_q.last_char && result_valid && result_stall)
  `RIDV_ASSERT_NEXT(a_count_saturates, clk, rst, advance && !char_q.last_char && char_count == ridv_pkg::COUNT_MAX, char_count == ridv_pkg::COUNT_MAX)

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// Resident ID number validator testbench
// Feeds ID numbers one character per transaction: directed corner cases,
// then mostly well-formed numbers with random content plus broken ones and
// noise, under several settings of today's date. A scoreboard predicts the
// status and gender of every number and checks each result transaction.
// ----------------------------------------------------------------------------
package ridv_tb_pkg;
  import ridv_pkg::*;

  localparam int WEIGHTS [17] = '{7, 9, 10, 5, 8, 4, 2, 1, 6, 3, 7, 9, 10, 5, 8, 4, 2};
  localparam logic [7:0] CHECK_SYMBOLS [11] =
    '{"1", "0", "X", "9", "8", "7", "6", "5", "4", "3", "2"};
  localparam int MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef enum int {
    ID_GOOD18, ID_GOOD15, ID_BAD_CHECK, ID_NONDIGIT,
    ID_BAD_PROV, ID_BAD_DATE, ID_BAD_LEN, ID_NOISE
  } id_kind_e;

  typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_e;

  function automatic bit is_leap(input int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic bit date_ok(input int y, m, d, ty, tm, td);
    int lim;
    if (y < 1900 || y > ty) return 1'b0;
    if (y * 10000 + m * 100 + d > ty * 10000 + tm * 100 + td) return 1'b0;
    if (m < 1 || m > 12) return 1'b0;
    lim = MONTH_DAYS[m - 1];
    if (m == 2 && is_leap(y)) lim = 29;
    return (d >= 1) && (d <= lim);
  endfunction

  class id_check_board;
    logic [13:0] today_year;
    logic [3:0]  today_month;
    logic [4:0]  today_day;
    logic [4:0]  count;
    logic [3:0]  wsum;
    logic [3:0]  digits [17];
    bit          nd_low;
    bit          nd_high;
    logic [7:0]  check_ch;
    result_t     verdicts_due [$];
    int          errors;

    function new();
      today_year  = RESET_YEAR;
      today_month = RESET_MONTH;
      today_day   = RESET_DAY;
      count       = '0;
      wsum        = '0;
      nd_low      = 1'b0;
      nd_high     = 1'b0;
      check_ch    = '0;
      errors      = 0;
      foreach (digits[i]) digits[i] = '0;
    endfunction

    function void set_today(input logic [1:0] idx, input logic [13:0] data);
      case (idx)
        CFG_TODAY_YEAR:  today_year  = data;
        CFG_TODAY_MONTH: today_month = data[3:0];
        CFG_TODAY_DAY:   today_day   = data[4:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return verdicts_due.size();
    endfunction

    function void note_failure(input string msg);
      errors++;
      if (errors <= 10) $display("MISMATCH: %s", msg);
    endfunction

    function void take_char(input char_t c);
      bit          is_dig;
      logic [3:0]  dv;
      int          a [17];
      int          prov;
      logic [7:0]  ch;
      result_t     r;
      is_dig = (c.char_code >= "0") && (c.char_code <= "9");
      dv = is_dig ? 4'(c.char_code - 8'h30) : 4'd0;
      if (count < 5'd17) begin
        digits[count] = dv;
        wsum = 4'((int'(wsum) + WEIGHTS[count] * int'(dv)) % 11);
        if (!is_dig) begin
          if (count < POS_SPLIT) nd_low = 1'b1;
          else nd_high = 1'b1;
        end
      end else if (count == POS_CHECK) begin
        check_ch = c.char_code;
      end
      if (count != COUNT_MAX) count++;
      if (!c.last_char) return;

      foreach (a[i]) a[i] = 0;
      r.status = ST_VALID;
      r.gender = 1'b0;
      if (count == LEN_SHORT) begin
        if (nd_low) begin
          r.status = ST_DIGIT;
        end else begin
          for (int i = 0; i < 6; i++) a[i] = digits[i];
          a[6] = 1;
          a[7] = 9;
          for (int i = 6; i < 15; i++) a[i + 2] = digits[i];
        end
      end else if (count == LEN_LONG) begin
        if (nd_low || nd_high) begin
          r.status = ST_DIGIT;
        end else begin
          ch = check_ch;
          if (ch >= "a" && ch <= "z") ch = ch - 8'h20;
          if (ch != CHECK_SYMBOLS[wsum]) r.status = ST_CHECK;
          for (int i = 0; i < 17; i++) a[i] = digits[i];
        end
      end else begin
        r.status = ST_LENGTH;
      end
      if (r.status == ST_VALID) begin
        prov = a[0] * 10 + a[1];
        if (prov < 11 || prov > 65) begin
          r.status = ST_PROVINCE;
        end else if (!date_ok(a[6] * 1000 + a[7] * 100 + a[8] * 10 + a[9],
                              a[10] * 10 + a[11], a[12] * 10 + a[13],
                              int'(today_year), int'(today_month), int'(today_day))) begin
          r.status = ST_DATE;
        end else begin
          r.gender = 1'(a[16] & 1);
        end
      end
      verdicts_due.insert(verdicts_due.size(), r);
      count    = '0;
      wsum     = '0;
      nd_low   = 1'b0;
      nd_high  = 1'b0;
      check_ch = '0;
    endfunction

    function void check_result(input result_t got);
      result_t want;
      if (verdicts_due.size() == 0) begin
        note_failure($sformatf("unexpected result: status %0d gender %0d",
                               got.status, got.gender));
        return;
      end
      want = verdicts_due.pop_front();
      if (got.status !== want.status)
        note_failure($sformatf("status expected %0d actual %0d", want.status, got.status));
      if (got.gender !== want.gender)
        note_failure($sformatf("gender expected %0d actual %0d (status %0d)",
                               want.gender, got.gender, want.status));
    endfunction
  endclass
endpackage

module tb_top;
  import ridv_pkg::*;
  import ridv_tb_pkg::*;

  localparam int QUIET_LIMIT = 2000;

  logic        clk;
  logic        rst;
  logic        char_valid;
  logic        char_stall;
  char_t       char_data;
  logic        result_valid;
  logic        result_stall;
  result_t     result_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [13:0] cfg_data;
  logic        moved;

  id_check_board sb;
  int burst_left;
  int chars_sent;

  resident_id_number_validator u_dut (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .char_data    (char_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  assign moved = (char_valid && !char_stall) || (result_valid && !result_stall) ||
                 (cfg_valid && cfg_ready);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && char_valid && !char_stall) sb.take_char(char_data);
    if (!rst && result_valid && !result_stall) sb.check_result(result_data);
  end

  initial begin : stall_pattern
    rx_mode_e mode;
    int left;
    result_stall = 1'b0;
    mode = RX_OPEN;
    left = 0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        mode = rx_mode_e'($urandom_range(0, 3));
        left = $urandom_range(5, 60);
      end
      left--;
      case (mode)
        RX_OPEN:  result_stall <= 1'b0;
        RX_LIGHT: result_stall <= ($urandom_range(0, 99) < 30);
        RX_HEAVY: result_stall <= ($urandom_range(0, 99) < 75);
        default:  result_stall <= ((left % 5) < 3);
      endcase
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (moved) quiet = 0;
      else quiet++;
    end
    $display("Test completed with failures");
    $finish;
  end

  task automatic send_char(input char_t c);
    int idle;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (idle > 0) begin
        char_valid <= 1'b0;
        repeat (idle) @(posedge clk);
      end
    end
    burst_left--;
    char_valid <= 1'b1;
    char_data  <= c;
    do @(posedge clk); while (char_stall);
  endtask

  task automatic send_number(input byte unsigned s [$]);
    char_t c;
    foreach (s[i]) begin
      c.char_code = s[i];
      c.last_char = (i == s.size() - 1);
      send_char(c);
      chars_sent++;
    end
  endtask

  task automatic settle();
    char_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_today(input int y, m, d);
    logic [1:0] idx [3];
    int         val [3];
    idx = '{CFG_TODAY_YEAR, CFG_TODAY_MONTH, CFG_TODAY_DAY};
    val = '{y, m, d};
    for (int k = 0; k < 3; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= 14'(val[k]);
      do @(posedge clk); while (!cfg_ready);
      sb.set_today(idx[k], 14'(val[k]));
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic void id_string(input int prov, yr, mo, dy, seq, input bit long_form,
                                    ref byte unsigned s [$]);
    int d [17];
    int sum;
    d[0] = (prov / 10) % 10;
    d[1] = prov % 10;
    for (int i = 2; i < 6; i++) d[i] = $urandom_range(0, 9);
    d[6]  = (yr / 1000) % 10;
    d[7]  = (yr / 100) % 10;
    d[8]  = (yr / 10) % 10;
    d[9]  = yr % 10;
    d[10] = (mo / 10) % 10;
    d[11] = mo % 10;
    d[12] = (dy / 10) % 10;
    d[13] = dy % 10;
    d[14] = (seq / 100) % 10;
    d[15] = (seq / 10) % 10;
    d[16] = seq % 10;
    s.delete();
    sum = 0;
    for (int i = 0; i < 17; i++) begin
      if (long_form || (i != 6 && i != 7)) s.insert(s.size(), 8'(8'h30 + d[i]));
      sum += WEIGHTS[i] * d[i];
    end
    if (long_form) s.insert(s.size(), CHECK_SYMBOLS[sum % 11]);
  endfunction

  task automatic random_number();
    byte unsigned s [$];
    id_kind_e     kind;
    int           roll, prov, yr, mo, dy, seq, hi, tm_c, td_c, n, pos;
    bit           long_form;
    byte unsigned b;
    hi = (sb.today_year > 14'd9999) ? 9999 : int'(sb.today_year);
    tm_c = (sb.today_month < 1) ? 1 : (sb.today_month > 12) ? 12 : int'(sb.today_month);
    td_c = (sb.today_day < 1) ? 1 : (sb.today_day > 28) ? 28 : int'(sb.today_day);
    yr = 1900;
    mo = 1;
    dy = 1;
    for (int t = 0; t < 30; t++) begin
      if ($urandom_range(0, 3) == 0) begin
        yr = hi;
        mo = $urandom_range(1, tm_c);
        dy = $urandom_range(1, td_c);
      end else begin
        yr = $urandom_range(1900, hi);
        mo = $urandom_range(1, 12);
        dy = $urandom_range(1, MONTH_DAYS[mo - 1] + ((mo == 2 && is_leap(yr)) ? 1 : 0));
      end
      if (date_ok(yr, mo, dy, int'(sb.today_year), int'(sb.today_month),
                  int'(sb.today_day))) break;
    end
    prov = $urandom_range(11, 65);
    seq = $urandom_range(0, 999);
    long_form = ($urandom_range(0, 3) != 0);
    roll = $urandom_range(0, 99);
    if (roll < 35)      kind = ID_GOOD18;
    else if (roll < 45) kind = ID_GOOD15;
    else if (roll < 55) kind = ID_BAD_CHECK;
    else if (roll < 65) kind = ID_NONDIGIT;
    else if (roll < 73) kind = ID_BAD_PROV;
    else if (roll < 85) kind = ID_BAD_DATE;
    else if (roll < 95) kind = ID_BAD_LEN;
    else                kind = ID_NOISE;

    case (kind)
      ID_GOOD18: begin
        id_string(prov, yr, mo, dy, seq, 1'b1, s);
        if (s[17] == "X" && $urandom_range(0, 1) == 1) s[17] = "x";
      end
      ID_GOOD15: begin
        id_string(prov, 1900 + yr % 100, mo, dy, seq, 1'b0, s);
      end
      ID_BAD_CHECK: begin
        id_string(prov, yr, mo, dy, seq, 1'b1, s);
        case ($urandom_range(0, 3))
          0:       s[17] = 8'(8'h30 + $urandom_range(0, 9));
          1:       s[17] = "X";
          2:       s[17] = "x";
          default: s[17] = 8'($urandom_range(0, 255));
        endcase
      end
      ID_NONDIGIT: begin
        id_string(prov, yr, mo, dy, seq, long_form, s);
        repeat ($urandom_range(1, 2)) begin
          pos = $urandom_range(0, long_form ? 16 : 14);
          b = 8'($urandom_range(0, 245));
          if (b >= 8'h30) b = b + 8'd10;
          s[pos] = b;
        end
      end
      ID_BAD_PROV: begin
        prov = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 10) : $urandom_range(66, 99);
        id_string(prov, yr, mo, dy, seq, long_form, s);
      end
      ID_BAD_DATE: begin
        case ($urandom_range(0, 6))
          0: mo = 0;
          1: mo = $urandom_range(13, 99);
          2: dy = 0;
          3: dy = $urandom_range(MONTH_DAYS[mo - 1] + 1, 99);
          4: begin
            yr = 1901 + 4 * $urandom_range(0, 24);
            mo = 2;
            dy = 29;
          end
          5: yr = $urandom_range(0, 1899);
          default: begin
            yr = (hi < 9999) ? $urandom_range(hi + 1, 9999) : 9999;
            mo = 12;
            dy = 31;
          end
        endcase
        id_string(prov, yr, mo, dy, seq, long_form, s);
      end
      ID_BAD_LEN: begin
        case ($urandom_range(0, 3))
          0:       n = $urandom_range(1, 14);
          1:       n = 16;
          2:       n = 17;
          default: n = $urandom_range(19, 40);
        endcase
        s.delete();
        repeat (n) begin
          if ($urandom_range(0, 9) == 0) s.insert(s.size(), 8'($urandom_range(0, 255)));
          else s.insert(s.size(), 8'(8'h30 + $urandom_range(0, 9)));
        end
      end
      default: begin
        n = $urandom_range(1, 35);
        s.delete();
        repeat (n) s.insert(s.size(), 8'($urandom_range(0, 255)));
      end
    endcase
    send_number(s);
  endtask

  initial begin : main
    byte unsigned s [$];
    int seq;
    int set_year [5];
    int set_month [5];
    int set_day [5];
    set_year  = '{9999, 1900, 2000, 16383, 1999};
    set_month = '{12, 1, 2, 15, 0};
    set_day   = '{31, 1, 29, 31, 0};
    sb = new();
    rst = 1'b1;
    char_valid = 1'b0;
    char_data = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_TODAY_YEAR;
    cfg_data = '0;
    burst_left = 0;
    chars_sent = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    id_string(11, 1900, 1, 1, 123, 1'b1, s);
    send_number(s);
    id_string(65, 2024, 1, 1, 124, 1'b1, s);
    send_number(s);
    id_string(10, 1990, 5, 5, 1, 1'b1, s);
    send_number(s);
    id_string(66, 1990, 5, 5, 2, 1'b1, s);
    send_number(s);
    id_string(0, 1990, 5, 5, 3, 1'b0, s);
    send_number(s);
    id_string(99, 1990, 5, 5, 4, 1'b1, s);
    send_number(s);
    id_string(30, 2024, 1, 2, 5, 1'b1, s);
    send_number(s);
    id_string(30, 1899, 12, 31, 6, 1'b1, s);
    send_number(s);
    id_string(30, 2000, 2, 29, 7, 1'b1, s);
    send_number(s);
    id_string(30, 1900, 2, 29, 8, 1'b1, s);
    send_number(s);
    id_string(30, 2023, 13, 1, 9, 1'b1, s);
    send_number(s);
    id_string(30, 2023, 0, 10, 10, 1'b1, s);
    send_number(s);
    id_string(30, 2023, 4, 31, 11, 1'b1, s);
    send_number(s);
    id_string(30, 2023, 1, 0, 12, 1'b1, s);
    send_number(s);
    id_string(44, 1985, 7, 20, 311, 1'b0, s);
    send_number(s);
    id_string(44, 1985, 7, 20, 312, 1'b0, s);
    s[3] = "A";
    send_number(s);
    id_string(44, 1985, 7, 20, 313, 1'b1, s);
    s[16] = "/";
    send_number(s);
    id_string(52, 1970, 3, 15, 777, 1'b1, s);
    s[17] = (s[17] == "0") ? "1" : "0";
    send_number(s);
    seq = 0;
    do begin
      id_string(23, 1988, 8, 8, seq, 1'b1, s);
      seq++;
    end while (s[17] != "X");
    s[17] = "x";
    send_number(s);
    id_string(37, 1966, 6, 6, 66, 1'b1, s);
    s[17] = 8'hB8;
    send_number(s);
    s.delete();
    s.insert(s.size(), "5");
    send_number(s);
    s.delete();
    repeat (33) s.insert(s.size(), 8'(8'h30 + $urandom_range(0, 9)));
    send_number(s);
    id_string(41, 1995, 9, 9, 99, 1'b1, s);
    void'(s.pop_back());
    send_number(s);
    id_string(41, 1995, 9, 9, 98, 1'b0, s);
    s.insert(s.size(), "1");
    send_number(s);
    id_string(41, 1995, 9, 9, 97, 1'b1, s);
    s.insert(s.size(), "7");
    send_number(s);

    while (chars_sent < 300) random_number();
    for (int p = 0; p < 5; p++) begin
      settle();
      write_today(set_year[p], set_month[p], set_day[p]);
      while (chars_sent < 300 + 310 * (p + 1)) random_number();
    end
    settle();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
